FILE: rtl/rbs_pkg.sv
// Shared types, constants and step function for the reversible bit scrambler.
package rbs_pkg;

    localparam int MAX_STEPS   = 4;
    localparam int STEP_IDX_W  = $clog2(MAX_STEPS);
    localparam int WORD_W      = 64;
    localparam int CTRL_W      = 15;
    localparam int POS_W       = 6;
    localparam int CFG_ADDR_W  = $clog2(2 * MAX_STEPS);
    localparam int DEF_NUM_STEPS = 4;

    typedef enum logic [2:0] {
        STEP_SWAP = 3'd0,
        STEP_FLIP = 3'd1,
        STEP_ADD  = 3'd2,
        STEP_SUB  = 3'd3,
        STEP_NONE = 3'd7
    } step_type_t;

    typedef logic [MAX_STEPS-1:0][CTRL_W-1:0] ctrl_array_t;
    typedef logic [MAX_STEPS-1:0][WORD_W-1:0] delta_array_t;

    typedef struct packed {
        logic              inverse;
        logic [WORD_W-1:0] word;
    } beat_t;

    function automatic logic [WORD_W-1:0] apply_step(
        input logic [WORD_W-1:0] w,
        input logic [CTRL_W-1:0] ctrl,
        input logic [WORD_W-1:0] delta,
        input logic              inverse
    );
        logic [2:0]        kind;
        logic [POS_W-1:0]  p1;
        logic [POS_W-1:0]  p2;
        logic              b1;
        logic              b2;
        logic [WORD_W-1:0] r;
        kind = ctrl[2:0];
        p1   = ctrl[8:3];
        p2   = ctrl[14:9];
        b1   = w[p1];
        b2   = w[p2];
        r    = w;
        if (inverse && kind == STEP_ADD)
        begin
            kind = STEP_SUB;
        end
        else if (inverse && kind == STEP_SUB)
        begin
            kind = STEP_ADD;
        end
        unique case (kind)
            STEP_SWAP:
            begin
                r[p1] = b2;
                r[p2] = b1;
            end
            STEP_FLIP: r = w ^ ({{(WORD_W-1){1'b0}}, 1'b1} << p1);
            STEP_ADD:  r = w + delta;
            STEP_SUB:  r = w - delta;
            default:   r = w;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/rbs_cfg_regs.sv
// Step control and delta register file, written through a plain write port.
module rbs_cfg_regs
    import rbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [WORD_W-1:0]     cfg_data,
    output ctrl_array_t           step_ctrl,
    output delta_array_t          step_delta
);

    ctrl_array_t  ctrl_reg;
    delta_array_t delta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_STEPS; i++)
            begin
                ctrl_reg[i]  <= CTRL_W'(STEP_NONE);
                delta_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_addr[CFG_ADDR_W-1] == 1'b0)
            begin
                ctrl_reg[cfg_addr[STEP_IDX_W-1:0]] <= cfg_data[CTRL_W-1:0];
            end
            else
            begin
                delta_reg[cfg_addr[STEP_IDX_W-1:0]] <= cfg_data;
            end
        end
    end

    assign step_ctrl  = ctrl_reg;
    assign step_delta = delta_reg;

endmodule

FILE: rtl/rbs_step_stage.sv
// One pipeline stage: applies one scramble step and holds the beat on stall.
module rbs_step_stage
    import rbs_pkg::*;
#(
    parameter int NUM_STEPS = DEF_NUM_STEPS,
    parameter int STAGE_IDX = 0
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  ctrl_array_t  step_ctrl,
    input  delta_array_t step_delta,
    input  logic         in_valid,
    output logic         in_ready,
    input  beat_t        in_beat,
    output logic         out_valid,
    input  logic         out_ready,
    output beat_t        out_beat
);

    localparam logic [STEP_IDX_W-1:0] FWD_IDX = STEP_IDX_W'(STAGE_IDX);
    localparam logic [STEP_IDX_W-1:0] INV_IDX = STEP_IDX_W'(NUM_STEPS - 1 - STAGE_IDX);

    logic                  valid_reg;
    beat_t                 beat_reg;
    beat_t                 beat_next;
    logic [STEP_IDX_W-1:0] idx;

    assign idx      = in_beat.inverse ? INV_IDX : FWD_IDX;
    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        beat_next.inverse = in_beat.inverse;
        beat_next.word    = apply_step(in_beat.word, step_ctrl[idx], step_delta[idx],
                                       in_beat.inverse);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            beat_reg <= beat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ready |=> valid_reg && $stable(beat_reg))
        else $error("stage beat changed while stalled");

endmodule

FILE: rtl/reversible_bit_scrambler.sv
// Top level of the reversible bit scrambler.
// Each 64-bit beat passes through NUM_STEPS register stages, one per configured
// step (swap, flip, add or subtract); one beat is taken every cycle unless a low
// m_tready stalls the pipeline; each stage holds 64-bit add and subtract logic.
// s_tuser[0] selects the direction: 0 applies steps 0 upward, 1 applies them in
// reverse order with add and subtract exchanged, undoing the forward transform.
// Registers 0..3 are the step controls (type bits 2..0, first position 8..3,
// second position 14..9), 4..7 the deltas; write them only while no beat is in
// flight. After reset every step is a no-op and words pass through unchanged.
module reversible_bit_scrambler
    import rbs_pkg::*;
#(
    parameter int NUM_STEPS = DEF_NUM_STEPS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [WORD_W-1:0]     cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [WORD_W-1:0]     s_tdata,   // data_word
    input  logic [0:0]            s_tuser,   // req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [WORD_W-1:0]     m_tdata    // result_word
);

    ctrl_array_t  step_ctrl;
    delta_array_t step_delta;

    logic  valid [NUM_STEPS+1];
    logic  ready [NUM_STEPS+1];
    beat_t beat  [NUM_STEPS+1];

    rbs_cfg_regs u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .step_ctrl  (step_ctrl),
        .step_delta (step_delta)
    );

    assign valid[0]        = s_tvalid;
    assign beat[0].inverse = s_tuser[0];
    assign beat[0].word    = s_tdata;
    assign s_tready        = ready[0];

    for (genvar k = 0; k < NUM_STEPS; k++)
    begin : g_stage
        rbs_step_stage #(
            .NUM_STEPS (NUM_STEPS),
            .STAGE_IDX (k)
        ) u_stage (
            .clk        (clk),
            .rst_n      (rst_n),
            .step_ctrl  (step_ctrl),
            .step_delta (step_delta),
            .in_valid   (valid[k]),
            .in_ready   (ready[k]),
            .in_beat    (beat[k]),
            .out_valid  (valid[k+1]),
            .out_ready  (ready[k+1]),
            .out_beat   (beat[k+1])
        );
    end

    assign ready[NUM_STEPS] = m_tready;
    assign m_tvalid         = valid[NUM_STEPS];
    assign m_tdata          = beat[NUM_STEPS].word;

    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input blocked while output stage is empty");

    a_ready_passes: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input blocked while sink is ready");

endmodule
